// ===== design/assert_macros.svh =====
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BRA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bra: same-cycle check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define BRA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bra: next-cycle check failed");

`endif

// ===== design/bra_pkg.sv =====
// shared constants and types for the best rational approximation block
package bra_pkg;

    // width of every item field and of the limit registers
    localparam int FIELD_W = 32;

    // configuration port geometry
    localparam int APB_DATA_W = 32;
    localparam int ADDR_W     = 3;
    localparam int REG_IDX_W  = 1;

    // register indexes
    typedef enum logic [REG_IDX_W-1:0] {
        REG_LIMIT_NUM = 1'b0,
        REG_LIMIT_DEN = 1'b1
    } reg_idx_t;

    // register reset values
    localparam logic [FIELD_W-1:0] LIMIT_NUM_RESET = 32'd16777215;
    localparam logic [FIELD_W-1:0] LIMIT_DEN_RESET = 32'd256;

endpackage

// ===== design/bra_ratio_if.sv =====
// input channel: ratio to approximate
interface bra_ratio_if import bra_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] ratio_top;
    logic [FIELD_W-1:0] ratio_bottom;

    modport source (output valid, output ratio_top, output ratio_bottom, input ready);
    modport sink (input valid, input ratio_top, input ratio_bottom, output ready);

endinterface

// ===== design/bra_best_if.sv =====
// output channel: best fraction within the limits
interface bra_best_if import bra_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] best_top;
    logic [FIELD_W-1:0] best_bottom;

    modport source (output valid, output best_top, output best_bottom, input ready);
    modport sink (input valid, input best_top, input best_bottom, output ready);

endinterface

// ===== design/best_rational_approximation.sv =====
// best rational approximation under numerator and denominator limits
//
// channel   dir  handshake     payload
// ratio     in   valid/ready   ratio_top, ratio_bottom
// best      out  valid/ready   best_top, best_bottom
// apb       in   psel/penable  limit_numerator (0x0), limit_denominator (0x4)
//
// one item at a time; one add/subtract unit is shared by a bit-serial divider
// and a shift-add multiplier, W = VALUE_WIDTH
// per euclid term: a check, a divide, two multiplies for the convergent and a test
// a limit hit adds the two bound divides, then the tie check and the semi-convergent
// multiplies; the result is then handed off to the output register
// rst_n resets the sequencer, the output register and the limits (to their reset values) at once
// a waiting result in the output register holds the sequencer in its last step
`include "assert_macros.svh"

module best_rational_approximation import bra_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    bra_ratio_if.sink         ratio,
    bra_best_if.source        best,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int W  = VALUE_WIDTH;
    localparam int PW = (2 * W > 64) ? 64 : 2 * W;
    localparam int AW = PW + 2;
    localparam int EW = (W > FIELD_W) ? W : FIELD_W;
    localparam int CW = $clog2(W);

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_DIV_TERM,
        S_MUL_CN,
        S_MUL_CD,
        S_TEST,
        S_PREP_D,
        S_DIV_TD,
        S_PREP_N,
        S_DIV_TN,
        S_DECIDE,
        S_MUL_P1,
        S_MUL_P2,
        S_MUL_SN,
        S_MUL_SD,
        S_DONE
    } state_t;

    // control and output registers
    state_t             state_reg, state_next;
    logic               out_valid_reg, out_valid_next;
    logic [FIELD_W-1:0] best_top_reg, best_top_next;
    logic [FIELD_W-1:0] best_bottom_reg, best_bottom_next;
    logic [FIELD_W-1:0] lim_num_reg, lim_num_next;
    logic [FIELD_W-1:0] lim_den_reg, lim_den_next;

    // datapath registers
    logic [W-1:0]  n_reg, n_next;
    logic [W-1:0]  d_reg, d_next;
    logic [W-1:0]  pn0_reg, pn0_next;
    logic [W-1:0]  pd0_reg, pd0_next;
    logic [W-1:0]  pn1_reg, pn1_next;
    logic [W-1:0]  pd1_reg, pd1_next;
    logic [W-1:0]  term_reg, term_next;
    logic [W-1:0]  mod_reg, mod_next;
    logic [W-1:0]  cn_reg, cn_next;
    logic [W-1:0]  cd_reg, cd_next;
    logic [W-1:0]  t_reg, t_next;
    logic [PW-1:0] prod_reg, prod_next;

    // shared unit registers
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  mpl_reg, mpl_next;
    logic [PW-1:0] mcand_reg, mcand_next;
    logic [PW-1:0] acc_reg, acc_next;

    // field and limit resizing to the datapath width
    logic [EW-1:0] top_ext, bottom_ext, lim_num_ext, lim_den_ext, pn1_ext, pd1_ext;
    logic [W-1:0]  top_w, bottom_w, lim_num_w, lim_den_w;

    assign top_ext     = EW'(ratio.ratio_top);
    assign bottom_ext  = EW'(ratio.ratio_bottom);
    assign lim_num_ext = EW'(lim_num_reg);
    assign lim_den_ext = EW'(lim_den_reg);
    assign pn1_ext     = EW'(pn1_reg);
    assign pd1_ext     = EW'(pd1_reg);
    assign top_w       = top_ext[W-1:0];
    assign bottom_w    = bottom_ext[W-1:0];
    assign lim_num_w   = lim_num_ext[W-1:0];
    assign lim_den_w   = lim_den_ext[W-1:0];

    // shared add/subtract unit
    logic [AW-1:0] add_a, add_b, add_res;
    logic          add_sub;
    logic [W:0]    div_trial;
    logic [W-1:0]  mul_base;
    logic          mul_busy;

    assign div_trial = {rem_reg, quo_reg[W-1]};
    assign mul_busy  = (mpl_reg != '0);
    assign mul_base  = (state_reg == S_MUL_CD || state_reg == S_MUL_SD) ? pd0_reg : pn0_reg;

    // operand select for the shared unit
    always_comb
    begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        case (state_reg)
            S_DIV_TERM, S_DIV_TD, S_DIV_TN:
            begin
                add_a   = AW'(div_trial);
                add_b   = AW'(dvs_reg);
                add_sub = 1'b1;
            end
            S_MUL_CN, S_MUL_CD, S_MUL_P1, S_MUL_P2, S_MUL_SN, S_MUL_SD:
            begin
                if (mul_busy)
                begin
                    add_a = AW'(acc_reg);
                    add_b = mpl_reg[0] ? AW'(mcand_reg) : '0;
                end
                else
                begin
                    add_a = AW'(mul_base);
                    add_b = AW'(acc_reg[W-1:0]);
                end
            end
            S_PREP_D:
            begin
                add_a   = AW'(lim_den_w);
                add_b   = AW'(pd0_reg);
                add_sub = 1'b1;
            end
            S_PREP_N:
            begin
                add_a   = AW'(lim_num_w);
                add_b   = AW'(pn0_reg);
                add_sub = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign add_res = add_a + (add_b ^ {AW{add_sub}}) + AW'(add_sub);

    // results of one divider step and of the adder
    logic         div_ge, div_last;
    logic [W-1:0] div_rem_step, div_quo_step, sum_w, sat_diff, half;

    assign div_ge       = ~add_res[AW-1];
    assign div_rem_step = div_ge ? add_res[W-1:0] : div_trial[W-1:0];
    assign div_quo_step = {quo_reg[W-2:0], div_ge};
    assign div_last     = (cnt_reg == CW'(W - 1));
    assign sum_w        = add_res[W-1:0];
    assign sat_diff     = add_res[AW-1] ? '0 : add_res[W-1:0];
    assign half         = term_reg >> 1;

    // apb register access
    reg_idx_t reg_idx;
    logic     cfg_write;

    assign reg_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_comb
    begin
        case (reg_idx)
            REG_LIMIT_NUM: prdata = APB_DATA_W'(lim_num_reg);
            REG_LIMIT_DEN: prdata = APB_DATA_W'(lim_den_reg);
            default:       prdata = '0;
        endcase
    end

    // channel ports
    assign ratio.ready      = (state_reg == S_IDLE);
    assign best.valid       = out_valid_reg;
    assign best.best_top    = best_top_reg;
    assign best.best_bottom = best_bottom_reg;

    // sequencer next state
    logic         div_start, mul_start;
    logic [W-1:0] div_dividend, div_divisor, mul_a, mul_b;

    always_comb
    begin
        state_next       = state_reg;
        out_valid_next   = out_valid_reg & ~best.ready;
        best_top_next    = best_top_reg;
        best_bottom_next = best_bottom_reg;
        lim_num_next     = lim_num_reg;
        lim_den_next     = lim_den_reg;
        n_next           = n_reg;
        d_next           = d_reg;
        pn0_next         = pn0_reg;
        pd0_next         = pd0_reg;
        pn1_next         = pn1_reg;
        pd1_next         = pd1_reg;
        term_next        = term_reg;
        mod_next         = mod_reg;
        cn_next          = cn_reg;
        cd_next          = cd_reg;
        t_next           = t_reg;
        prod_next        = prod_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        dvs_next         = dvs_reg;
        cnt_next         = cnt_reg;
        mpl_next         = mpl_reg;
        mcand_next       = mcand_reg;
        acc_next         = acc_reg;
        div_start        = 1'b0;
        div_dividend     = '0;
        div_divisor      = '0;
        mul_start        = 1'b0;
        mul_a            = '0;
        mul_b            = '0;

        // configuration writes
        if (cfg_write)
        begin
            case (reg_idx)
                REG_LIMIT_NUM: lim_num_next = pwdata[FIELD_W-1:0];
                REG_LIMIT_DEN: lim_den_next = pwdata[FIELD_W-1:0];
                default:
                begin
                end
            endcase
        end

        // one divider step in every division state
        if (state_reg == S_DIV_TERM || state_reg == S_DIV_TD || state_reg == S_DIV_TN)
        begin
            rem_next = div_rem_step;
            quo_next = div_quo_step;
            cnt_next = cnt_reg + CW'(1);
        end

        // one shift-add step in every multiply state while bits remain
        if (mul_busy)
        begin
            acc_next   = add_res[PW-1:0];
            mcand_next = mcand_reg << 1;
            mpl_next   = mpl_reg >> 1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (ratio.valid)
                begin
                    n_next     = top_w;
                    d_next     = bottom_w;
                    pn0_next   = '0;
                    pd0_next   = W'(1);
                    pn1_next   = W'(1);
                    pd1_next   = '0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (d_reg == '0)
                    state_next = S_DONE;
                else
                begin
                    div_start    = 1'b1;
                    div_dividend = n_reg;
                    div_divisor  = d_reg;
                    state_next   = S_DIV_TERM;
                end
            end
            S_DIV_TERM:
            begin
                if (div_last)
                begin
                    term_next  = div_quo_step;
                    mod_next   = div_rem_step;
                    mul_start  = 1'b1;
                    mul_a      = div_quo_step;
                    mul_b      = pn1_reg;
                    state_next = S_MUL_CN;
                end
            end
            S_MUL_CN:
            begin
                if (!mul_busy)
                begin
                    cn_next    = sum_w;
                    mul_start  = 1'b1;
                    mul_a      = term_reg;
                    mul_b      = pd1_reg;
                    state_next = S_MUL_CD;
                end
            end
            S_MUL_CD:
            begin
                if (!mul_busy)
                begin
                    cd_next    = sum_w;
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                if (cn_reg > lim_num_w || cd_reg > lim_den_w)
                    state_next = S_PREP_D;
                else
                begin
                    pn0_next   = pn1_reg;
                    pn1_next   = cn_reg;
                    pd0_next   = pd1_reg;
                    pd1_next   = cd_reg;
                    n_next     = d_reg;
                    d_next     = mod_reg;
                    state_next = S_CHECK;
                end
            end
            // denominator bound of the semi-convergent term
            S_PREP_D:
            begin
                t_next = '1;
                if (pd1_reg != '0)
                begin
                    div_start    = 1'b1;
                    div_dividend = sat_diff;
                    div_divisor  = pd1_reg;
                    state_next   = S_DIV_TD;
                end
                else
                    state_next = S_PREP_N;
            end
            S_DIV_TD:
            begin
                if (div_last)
                begin
                    t_next     = div_quo_step;
                    state_next = S_PREP_N;
                end
            end
            // numerator bound, the smaller one wins
            S_PREP_N:
            begin
                if (pn1_reg != '0)
                begin
                    div_start    = 1'b1;
                    div_dividend = sat_diff;
                    div_divisor  = pn1_reg;
                    state_next   = S_DIV_TN;
                end
                else
                    state_next = S_DECIDE;
            end
            S_DIV_TN:
            begin
                if (div_last)
                begin
                    if (div_quo_step < t_reg)
                        t_next = div_quo_step;
                    state_next = S_DECIDE;
                end
            end
            // semi-convergent against previous convergent
            S_DECIDE:
            begin
                if (t_reg > half)
                begin
                    mul_start  = 1'b1;
                    mul_a      = t_reg;
                    mul_b      = pn1_reg;
                    state_next = S_MUL_SN;
                end
                else if (!term_reg[0] && t_reg == half)
                begin
                    mul_start  = 1'b1;
                    mul_a      = pd0_reg;
                    mul_b      = d_reg;
                    state_next = S_MUL_P1;
                end
                else
                    state_next = S_DONE;
            end
            // tie on the term: compare cross products of the denominators and the remainders
            S_MUL_P1:
            begin
                if (!mul_busy)
                begin
                    prod_next  = acc_reg;
                    mul_start  = 1'b1;
                    mul_a      = pd1_reg;
                    mul_b      = mod_reg;
                    state_next = S_MUL_P2;
                end
            end
            S_MUL_P2:
            begin
                if (!mul_busy)
                begin
                    if (prod_reg > acc_reg)
                    begin
                        mul_start  = 1'b1;
                        mul_a      = t_reg;
                        mul_b      = pn1_reg;
                        state_next = S_MUL_SN;
                    end
                    else
                        state_next = S_DONE;
                end
            end
            S_MUL_SN:
            begin
                if (!mul_busy)
                begin
                    pn1_next   = sum_w;
                    mul_start  = 1'b1;
                    mul_a      = t_reg;
                    mul_b      = pd1_reg;
                    state_next = S_MUL_SD;
                end
            end
            S_MUL_SD:
            begin
                if (!mul_busy)
                begin
                    pd1_next   = sum_w;
                    state_next = S_DONE;
                end
            end
            // hand the result to the output register once it is free
            S_DONE:
            begin
                if (!out_valid_reg || best.ready)
                begin
                    best_top_next    = pn1_ext[FIELD_W-1:0];
                    best_bottom_next = pd1_ext[FIELD_W-1:0];
                    out_valid_next   = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        // load the shared unit for a new operation
        if (div_start)
        begin
            rem_next = '0;
            quo_next = div_dividend;
            dvs_next = div_divisor;
            cnt_next = '0;
        end
        if (mul_start)
        begin
            mpl_next   = mul_a;
            mcand_next = PW'(mul_b);
            acc_next   = '0;
        end
    end

    // state, output register and limits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            best_top_reg    <= '0;
            best_bottom_reg <= '0;
            lim_num_reg     <= LIMIT_NUM_RESET;
            lim_den_reg     <= LIMIT_DEN_RESET;
        end
        else
        begin
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
            best_top_reg    <= best_top_next;
            best_bottom_reg <= best_bottom_next;
            lim_num_reg     <= lim_num_next;
            lim_den_reg     <= lim_den_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        d_reg     <= d_next;
        pn0_reg   <= pn0_next;
        pd0_reg   <= pd0_next;
        pn1_reg   <= pn1_next;
        pd1_reg   <= pd1_next;
        term_reg  <= term_next;
        mod_reg   <= mod_next;
        cn_reg    <= cn_next;
        cd_reg    <= cd_next;
        t_reg     <= t_next;
        prod_reg  <= prod_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        dvs_reg   <= dvs_next;
        cnt_reg   <= cnt_next;
        mpl_reg   <= mpl_next;
        mcand_reg <= mcand_next;
        acc_reg   <= acc_next;
    end

    // finished result waiting on a busy receiver
    logic done_stalled;

    assign done_stalled = (state_reg == S_DONE) && best.valid && !best.ready;

    // checks on the sequencer and the divider
    `BRA_ASSERT_NXT(a_busy_after_accept, ratio.valid && ratio.ready, !ratio.ready)
    `BRA_ASSERT_IMP(a_remainder_below_divisor, state_reg == S_TEST, mod_reg < d_reg)
    `BRA_ASSERT_NXT(a_hold_while_stalled, done_stalled, state_reg == S_DONE)
    `BRA_ASSERT_IMP(a_result_from_done, $rose(best.valid), $past(state_reg == S_DONE))

endmodule
